@@ hdl/matrix_multiply_engine_top_defines.svh @@
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define MME_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/mme_pkg.sv @@
`default_nettype none

package mme_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 16;
    localparam int SUM_W      = 35;
    localparam int PROD_W     = 2 * ELEM_WIDTH;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int APB_ADDR_W = CFG_IDX_W + 2;
    localparam int APB_DATA_W = 32;
    localparam int OP_W       = 2;
    localparam int VALUE_W    = 16;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [DIM_W-1:0]             dim_t;
    typedef logic [ADDR_W-1:0]            addr_t;
    typedef logic [CFG_W-1:0]             cfg_t;
    typedef logic [OP_W-1:0]              op_t;
    typedef logic [CFG_IDX_W-1:0]         reg_idx_t;

    localparam op_t OP_LOAD_A   = 2'd0;
    localparam op_t OP_LOAD_B   = 2'd1;
    localparam op_t OP_MULTIPLY = 2'd2;

    localparam reg_idx_t REG_A_ROWS = 2'd0;
    localparam reg_idx_t REG_A_COLS = 2'd1;
    localparam reg_idx_t REG_B_ROWS = 2'd2;
    localparam reg_idx_t REG_B_COLS = 2'd3;

    localparam cfg_t CFG_RESET = 4'd8;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_MISMATCH
    } state_t;

    typedef struct packed {
        dim_t ar;
        dim_t ac;
        dim_t br;
        dim_t bc;
    } dims_t;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } issue_t;

    typedef struct packed {
        logic done;
        logic busy;
    } mac_stat_t;

    function automatic dim_t eff_dim(input cfg_t r);
        dim_t d;
        if (r == '0) begin
            d = DIM_W'(1);
        end else if (r > CFG_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(r);
        end
        return d;
    endfunction

    function automatic addr_t addr_of(input idx_t r, input idx_t c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
    endfunction

endpackage

`default_nettype wire

@@ hdl/mme_ram.sv @@
`default_nettype none

module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/mme_mac.sv @@
`default_nettype none

module mme_mac (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mme_pkg::issue_t    issue,
    input  wire mme_pkg::elem_t     a_op,
    input  wire mme_pkg::elem_t     b_op,
    output mme_pkg::sum_t           sum,
    output mme_pkg::mac_stat_t      stat
);

    import mme_pkg::*;

    issue_t s1_reg;
    issue_t s2_reg;
    prod_t  prod_reg;
    prod_t  prod_next;
    sum_t   acc_reg;
    sum_t   acc_next;
    logic   done_reg;

    assign prod_next = a_op * b_op;
    assign acc_next  = (s2_reg.first ? sum_t'(0) : acc_reg) + sum_t'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
            acc_reg  <= '0;
        end else begin
            s1_reg   <= issue;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg.vld && s2_reg.last;
            if (s2_reg.vld) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_reg.vld) begin
            prod_reg <= prod_next;
        end
    end

    assign sum       = acc_reg;
    assign stat.done = done_reg;
    assign stat.busy = s1_reg.vld || s2_reg.vld || done_reg;

endmodule

`default_nettype wire

@@ hdl/mme_ctrl.sv @@
`default_nettype none
`include "matrix_multiply_engine_top_defines.svh"

module mme_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mme_pkg::dims_t        dims,
    input  wire logic                  s_valid,
    input  wire mme_pkg::op_t          s_op,
    output logic                       s_ready,
    output mme_pkg::issue_t            issue,
    output mme_pkg::addr_t             a_addr,
    output mme_pkg::addr_t             b_addr,
    input  wire mme_pkg::mac_stat_t    mac_stat,
    input  wire mme_pkg::sum_t         mac_sum,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mme_pkg::sum_t              m_sum,
    output mme_pkg::idx_t              m_out_row,
    output mme_pkg::idx_t              m_out_col,
    output logic                       m_status,
    output logic                       m_last
);

    import mme_pkg::*;

    state_t state_reg, state_next;
    idx_t   i_reg, i_next;
    idx_t   j_reg, j_next;
    idx_t   n_reg, n_next;
    logic   sum_rdy_reg, sum_rdy_next;
    logic   m_valid_reg, m_valid_next;
    sum_t   m_sum_reg, out_sum_next;
    idx_t   m_row_reg, out_row_next;
    idx_t   m_col_reg, out_col_next;
    logic   m_status_reg, out_status_next;
    logic   m_last_reg, out_last_next;
    logic   out_load;
    logic   out_free;
    logic   row_end;
    logic   col_end;
    logic   term_end;

    assign out_free = !m_valid_reg || m_ready;
    assign row_end  = DIM_W'(i_reg) == dims.ar - DIM_W'(1);
    assign col_end  = DIM_W'(j_reg) == dims.bc - DIM_W'(1);
    assign term_end = DIM_W'(n_reg) == dims.ac - DIM_W'(1);

    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        issue           = '0;
        out_load        = 1'b0;
        out_sum_next    = mac_sum;
        out_row_next    = i_reg;
        out_col_next    = j_reg;
        out_status_next = STATUS_OK;
        out_last_next   = row_end && col_end;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_op == OP_MULTIPLY) begin
                    if (dims.ac != dims.br) begin
                        state_next = ST_MISMATCH;
                    end else begin
                        i_next     = '0;
                        j_next     = '0;
                        n_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                issue.vld   = 1'b1;
                issue.first = n_reg == '0;
                issue.last  = term_end;
                if (term_end) begin
                    n_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    n_next = n_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if ((sum_rdy_reg || mac_stat.done) && out_free) begin
                    out_load = 1'b1;
                    if (row_end && col_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        if (col_end) begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end else begin
                            j_next = j_reg + IDX_W'(1);
                        end
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_MISMATCH: begin
                out_sum_next    = '0;
                out_row_next    = '0;
                out_col_next    = '0;
                out_status_next = STATUS_MISMATCH;
                out_last_next   = 1'b1;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        sum_rdy_next = (sum_rdy_reg || mac_stat.done) && !out_load;
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            sum_rdy_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            sum_rdy_reg <= sum_rdy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sum_reg    <= out_sum_next;
            m_row_reg    <= out_row_next;
            m_col_reg    <= out_col_next;
            m_status_reg <= out_status_next;
            m_last_reg   <= out_last_next;
        end
    end

    assign s_ready   = state_reg == ST_IDLE;
    assign a_addr    = addr_of(i_reg, n_reg);
    assign b_addr    = addr_of(n_reg, j_reg);
    assign m_valid   = m_valid_reg;
    assign m_sum     = m_sum_reg;
    assign m_out_row = m_row_reg;
    assign m_out_col = m_col_reg;
    assign m_status  = m_status_reg;
    assign m_last    = m_last_reg;

    `MME_ASSERT_SAME(a_load_free, out_load, !m_valid_reg || m_ready, "result overwritten")
    `MME_ASSERT_SAME(a_done_drain, mac_stat.done, state_reg == ST_DRAIN, "sum done out of drain")
    `MME_ASSERT_SAME(a_idle_quiet, state_reg == ST_IDLE, !mac_stat.busy, "datapath busy in idle")
    `MME_ASSERT_SAME(a_mismatch_form, m_valid_reg && m_status_reg, m_last_reg && (m_sum_reg == '0), "bad mismatch item")
    `MME_ASSERT_NEXT(a_last_idle, out_load && out_last_next, state_reg == ST_IDLE, "no idle after last")

endmodule

`default_nettype wire

@@ hdl/matrix_multiply_engine_top.sv @@
// Matrix multiply engine for up to 8 x 8 matrices of signed Q8.8 elements.
// Input channel (s_valid/s_ready): op 0 loads an element of A, op 1 loads an
// element of B at (s_row, s_col), op 2 multiplies. Loads outside the configured
// dimensions are dropped. A load is taken every cycle while the engine is idle.
// Result channel (m_valid/m_ready): a multiply sends C = A x B in row-major
// order as exact Q19.16 sums, m_last marking the final item. If the columns of
// A differ from the rows of B, a single item with m_status set is sent.
// Each element of C is formed by one multiplier and one accumulator over the
// inner dimension: the sequencer issues the terms of one element, then waits
// in its drain state until that sum is loaded into the output register, and
// only then starts the next element. s_ready stays low during a multiply.
// The last result sits in an output register, so the next command is taken
// while it waits. A stalled m_ready holds the item and pauses the sequencer.
// The APB port holds the four dimension registers at byte addresses 0, 4, 8
// and 12; write them only while no multiply is in progress.
// Synchronous reset clears both matrices to zero and sets all dimensions to 8.
`default_nettype none

module matrix_multiply_engine_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [mme_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [mme_pkg::APB_DATA_W-1:0]        pwdata,
    output logic      [mme_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                       pready,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [mme_pkg::OP_W-1:0]              s_op,
    input  wire logic [mme_pkg::IDX_W-1:0]             s_row,
    input  wire logic [mme_pkg::IDX_W-1:0]             s_col,
    input  wire logic signed [mme_pkg::VALUE_W-1:0]    s_value,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [mme_pkg::SUM_W-1:0]           m_sum,
    output logic      [mme_pkg::IDX_W-1:0]             m_out_row,
    output logic      [mme_pkg::IDX_W-1:0]             m_out_col,
    output logic                                       m_status,
    output logic                                       m_last
);

    import mme_pkg::*;

    cfg_t              a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    cfg_t              rd_reg;
    reg_idx_t          cfg_idx;
    logic              cfg_we;
    dims_t             dims;
    logic              accept;
    logic              a_we, b_we;
    addr_t             waddr;
    elem_t             wdata;
    logic [DEPTH-1:0]  a_vld_reg, b_vld_reg;
    logic              a_hit_reg, b_hit_reg;
    addr_t             a_addr, b_addr;
    logic [ELEM_WIDTH-1:0] a_q, b_q;
    elem_t             a_op, b_op;
    issue_t            issue;
    mac_stat_t         mac_stat;
    sum_t              mac_sum;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg <= CFG_RESET;
            a_cols_reg <= CFG_RESET;
            b_rows_reg <= CFG_RESET;
            b_cols_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_A_ROWS: a_rows_reg <= pwdata[CFG_W-1:0];
                REG_A_COLS: a_cols_reg <= pwdata[CFG_W-1:0];
                REG_B_ROWS: b_rows_reg <= pwdata[CFG_W-1:0];
                REG_B_COLS: b_cols_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_A_ROWS: rd_reg = a_rows_reg;
            REG_A_COLS: rd_reg = a_cols_reg;
            REG_B_ROWS: rd_reg = b_rows_reg;
            REG_B_COLS: rd_reg = b_cols_reg;
            default:    rd_reg = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W - CFG_W){1'b0}}, rd_reg};

    assign dims.ar = eff_dim(a_rows_reg);
    assign dims.ac = eff_dim(a_cols_reg);
    assign dims.br = eff_dim(b_rows_reg);
    assign dims.bc = eff_dim(b_cols_reg);

    assign accept = s_valid && s_ready;
    assign waddr  = addr_of(s_row, s_col);
    assign wdata  = elem_t'(s_value);
    assign a_we   = accept && s_op == OP_LOAD_A
                    && DIM_W'(s_row) < dims.ar && DIM_W'(s_col) < dims.ac;
    assign b_we   = accept && s_op == OP_LOAD_B
                    && DIM_W'(s_row) < dims.br && DIM_W'(s_col) < dims.bc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= '0;
            b_vld_reg <= '0;
        end else begin
            if (a_we) begin
                a_vld_reg[waddr] <= 1'b1;
            end
            if (b_we) begin
                b_vld_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_hit_reg <= a_vld_reg[a_addr];
        b_hit_reg <= b_vld_reg[b_addr];
    end

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_addr),
        .rdata (a_q)
    );

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_addr),
        .rdata (b_q)
    );

    assign a_op = a_hit_reg ? elem_t'(a_q) : elem_t'(0);
    assign b_op = b_hit_reg ? elem_t'(b_q) : elem_t'(0);

    mme_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .a_op    (a_op),
        .b_op    (b_op),
        .sum     (mac_sum),
        .stat    (mac_stat)
    );

    mme_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dims      (dims),
        .s_valid   (s_valid),
        .s_op      (s_op),
        .s_ready   (s_ready),
        .issue     (issue),
        .a_addr    (a_addr),
        .b_addr    (b_addr),
        .mac_stat  (mac_stat),
        .mac_sum   (mac_sum),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sum     (m_sum),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_status  (m_status),
        .m_last    (m_last)
    );

endmodule

`default_nettype wire

@@ sim/matrix_product_checker.sv @@
module matrix_product_checker
    import mme_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic                         pready,
    input  wire logic [APB_ADDR_W-1:0]        paddr,
    input  wire logic [APB_DATA_W-1:0]        pwdata,
    input  wire logic                         s_valid,
    input  wire logic                         s_ready,
    input  wire logic [OP_W-1:0]              s_op,
    input  wire logic [IDX_W-1:0]             s_row,
    input  wire logic [IDX_W-1:0]             s_col,
    input  wire logic signed [VALUE_W-1:0]    s_value,
    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire logic signed [SUM_W-1:0]      m_sum,
    input  wire logic [IDX_W-1:0]             m_out_row,
    input  wire logic [IDX_W-1:0]             m_out_col,
    input  wire logic                         m_status,
    input  wire logic                         m_last,
    output int                                mismatches,
    output int                                products_outstanding,
    output int                                items_taken,
    output int                                products_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sum_t sum;
        idx_t row;
        idx_t col;
        logic status;
        logic last;
    } product_t;

    elem_t    a_mat [DEPTH];
    elem_t    b_mat [DEPTH];
    cfg_t     dim_reg [4];
    sum_t     last_dot;
    product_t pending_products [$];
    int       fail_total;
    int       taken_total;
    int       seen_total;

    function automatic int dim_in_use(input cfg_t r);
        if (r == '0) begin
            return 1;
        end
        if (r > cfg_t'(MAX_DIM)) begin
            return MAX_DIM;
        end
        return int'(r);
    endfunction

    task automatic report_mismatch(input string what);
        fail_total++;
        if (fail_total <= 30) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endtask

    task automatic predict_item(input op_t op, input idx_t row, input idx_t col,
                                input elem_t value);
        int ar, ac, br, bc;
        int i, j, n;
        sum_t dot;
        product_t p;
        ar = dim_in_use(dim_reg[REG_A_ROWS]);
        ac = dim_in_use(dim_reg[REG_A_COLS]);
        br = dim_in_use(dim_reg[REG_B_ROWS]);
        bc = dim_in_use(dim_reg[REG_B_COLS]);
        case (op)
            OP_LOAD_A: begin
                if (int'(row) < ar && int'(col) < ac) begin
                    a_mat[int'(row) * MAX_DIM + int'(col)] = value;
                end
            end
            OP_LOAD_B: begin
                if (int'(row) < br && int'(col) < bc) begin
                    b_mat[int'(row) * MAX_DIM + int'(col)] = value;
                end
            end
            OP_MULTIPLY: begin
                if (ac != br) begin
                    p.sum    = '0;
                    p.row    = '0;
                    p.col    = '0;
                    p.status = STATUS_MISMATCH;
                    p.last   = 1'b1;
                    pending_products.push_back(p);
                end else begin
                    for (i = 0; i < ar; i++) begin
                        for (j = 0; j < bc; j++) begin
                            dot = '0;
                            for (n = 0; n < ac; n++) begin
                                dot = dot + a_mat[i * MAX_DIM + n] * b_mat[n * MAX_DIM + j];
                            end
                            last_dot = dot;
                            p.sum    = dot;
                            p.row    = idx_t'(i);
                            p.col    = idx_t'(j);
                            p.status = STATUS_OK;
                            p.last   = (i == ar - 1) && (j == bc - 1);
                            pending_products.push_back(p);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_product();
        product_t want;
        if (pending_products.size() == 0) begin
            report_mismatch($sformatf("unexpected result (%0d,%0d) sum %0d status %0b last %0b",
                                      m_out_row, m_out_col, m_sum, m_status, m_last));
        end else begin
            want = pending_products.pop_front();
            if (m_sum !== want.sum || m_out_row !== want.row || m_out_col !== want.col ||
                m_status !== want.status || m_last !== want.last) begin
                report_mismatch($sformatf(
                    "got (%0d,%0d) sum %0d st %0b last %0b, want (%0d,%0d) sum %0d st %0b last %0b",
                    m_out_row, m_out_col, m_sum, m_status, m_last,
                    want.row, want.col, $signed(want.sum), want.status, want.last));
            end
        end
        seen_total++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                a_mat[k] = '0;
                b_mat[k] = '0;
            end
            for (int k = 0; k < 4; k++) begin
                dim_reg[k] = CFG_RESET;
            end
            last_dot = '0;
            pending_products.delete();
            fail_total  = 0;
            taken_total = 0;
            seen_total  = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                dim_reg[paddr[APB_ADDR_W-1:2]] = pwdata[CFG_W-1:0];
            end
            if (m_valid && m_ready) begin
                check_product();
            end
            if (s_valid && s_ready) begin
                taken_total++;
                predict_item(s_op, s_row, s_col, s_value);
            end
        end
        mismatches           <= fail_total;
        products_outstanding <= pending_products.size();
        items_taken          <= taken_total;
        products_seen        <= seen_total;
    end

endmodule

@@ sim/matrix_multiply_engine_top_tb.sv @@
module matrix_multiply_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    localparam int  CYCLE_LIMIT   = 20_000_000;
    localparam int  DRAIN_CYCLES  = 24;
    localparam int  RANDOM_ITEMS  = 300;
    localparam op_t OP_UNUSED     = 2'd3;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr   = '0;
    logic [APB_DATA_W-1:0]      pwdata  = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    op_t                        s_op    = OP_LOAD_A;
    idx_t                       s_row   = '0;
    idx_t                       s_col   = '0;
    logic signed [VALUE_W-1:0]  s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SUM_W-1:0]    m_sum;
    idx_t                       m_out_row;
    idx_t                       m_out_col;
    logic                       m_status;
    logic                       m_last;

    int mismatches;
    int products_outstanding;
    int items_taken;
    int products_seen;

    logic       calm = 1'b0;
    int         stall_left = 0;
    int         cycle_count = 0;
    logic [15:0] corner_values [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    matrix_multiply_engine_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_row     (s_row),
        .s_col     (s_col),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sum     (m_sum),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_status  (m_status),
        .m_last    (m_last)
    );

    matrix_product_checker checker_i (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .pready               (pready),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_op                 (s_op),
        .s_row                (s_row),
        .s_col                (s_col),
        .s_value              (s_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_sum                (m_sum),
        .m_out_row            (m_out_row),
        .m_out_col            (m_out_col),
        .m_status             (m_status),
        .m_last               (m_last),
        .mismatches           (mismatches),
        .products_outstanding (products_outstanding),
        .items_taken          (items_taken),
        .products_seen        (products_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles.", CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic int idle_cycles();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // A size of 1 may also be written as 0, and a size of 8 as anything above 8.
    function automatic cfg_t raw_size(input int size);
        if (size == MAX_DIM) begin
            return cfg_t'($urandom_range(MAX_DIM, 15));
        end
        if (size == 1) begin
            return cfg_t'($urandom_range(0, 1));
        end
        return cfg_t'(size);
    endfunction

    always @(negedge aclk) begin
        stall_left = (stall_left > 0) ? stall_left : idle_cycles();
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input op_t op, input idx_t row, input idx_t col,
                             input logic [15:0] value);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_row   <= row;
        s_col   <= col;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_for_products();
        s_valid <= 1'b0;
        while (products_outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_dims(input cfg_t ar, input cfg_t ac, input cfg_t br, input cfg_t bc);
        cfg_t raw [4];
        int   i;
        wait_for_products();
        raw[REG_A_ROWS] = ar;
        raw[REG_A_COLS] = ac;
        raw[REG_B_ROWS] = br;
        raw[REG_B_COLS] = bc;
        for (i = 0; i < 4; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {reg_idx_t'(i), 2'b00};
            pwdata  <= APB_DATA_W'(raw[i]);
            @(negedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
            @(negedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int          useful;
        int          settings;
        int          ar, ac, br, bc;
        int          k;
        op_t         op;
        idx_t        r, c;
        logic [15:0] value;

        useful   = 0;
        settings = 1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Full 8 x 8 sizes from reset: largest magnitudes in row 0 of A and column 0 of B.
        for (k = 0; k < MAX_DIM; k++) begin
            send_item(OP_LOAD_A, 3'd0, idx_t'(k), 16'h8000);
        end
        for (k = 0; k < MAX_DIM; k++) begin
            send_item(OP_LOAD_B, idx_t'(k), 3'd0, 16'h8000);
        end
        send_item(OP_LOAD_B, 3'd0, 3'd1, 16'h7FFF);
        send_item(OP_LOAD_A, 3'd7, 3'd7, 16'h7FFF);
        send_item(OP_LOAD_B, 3'd7, 3'd7, 16'h8000);
        send_item(OP_UNUSED, 3'd7, 3'd7, 16'hFFFF);
        send_item(OP_MULTIPLY, 3'd0, 3'd0, 16'h0000);

        // Zero reads as 1 and 15 as 8, so the inner sizes differ.
        write_dims(4'd0, 4'd0, 4'd15, 4'd1);
        settings++;
        send_item(OP_MULTIPLY, 3'd5, 3'd2, 16'h1234);

        // A 1 x 8 by 8 x 1 product; loads past the sizes in use are dropped.
        write_dims(4'd0, 4'd15, 4'd9, 4'd1);
        settings++;
        send_item(OP_LOAD_A, 3'd1, 3'd0, 16'h7FFF);
        send_item(OP_LOAD_B, 3'd0, 3'd1, 16'h0001);
        send_item(OP_MULTIPLY, 3'd7, 3'd7, 16'hFFFF);

        while (useful < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                ar = MAX_DIM;
                bc = MAX_DIM;
            end else begin
                ar = $urandom_range(1, 4);
                bc = $urandom_range(1, 4);
            end
            ac = $urandom_range(1, MAX_DIM);
            br = ac;
            if ($urandom_range(0, 7) == 0) begin
                while (br == ac) br = $urandom_range(1, MAX_DIM);
            end
            write_dims(raw_size(ar), raw_size(ac), raw_size(br), raw_size(bc));
            settings++;

            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(1, ar * ac + br * bc)) begin
                    value = ($urandom_range(0, 7) == 0) ? corner_values[$urandom_range(0, 3)]
                                                        : 16'($urandom);
                    if ($urandom_range(0, 9) == 0) begin
                        // The spare opcode, or an A load beyond the sizes in use.
                        if ((ar == MAX_DIM && ac == MAX_DIM) || $urandom_range(0, 2) == 0) begin
                            send_item(OP_UNUSED, idx_t'($urandom), idx_t'($urandom), value);
                        end else if (ar < MAX_DIM) begin
                            send_item(OP_LOAD_A, idx_t'($urandom_range(ar, MAX_DIM - 1)),
                                      idx_t'($urandom), value);
                        end else begin
                            send_item(OP_LOAD_A, idx_t'($urandom),
                                      idx_t'($urandom_range(ac, MAX_DIM - 1)), value);
                        end
                    end else begin
                        op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
                        if (op == OP_LOAD_A) begin
                            r = idx_t'($urandom_range(0, ar - 1));
                            c = idx_t'($urandom_range(0, ac - 1));
                        end else begin
                            r = idx_t'($urandom_range(0, br - 1));
                            c = idx_t'($urandom_range(0, bc - 1));
                        end
                        send_item(op, r, c, value);
                        useful++;
                    end
                end
                send_item(OP_MULTIPLY, idx_t'($urandom), idx_t'($urandom), 16'($urandom));
                useful++;
                if ($urandom_range(0, 3) == 0) begin
                    wait_for_products();
                end
            end
        end

        calm = 1'b0;
        wait_for_products();

        $display("Sent %0d input items across %0d size settings, saturated and mismatched ones",
                 items_taken, settings);
        $display("among them, and compared %0d product items with the prediction.", products_seen);
        if (mismatches == 0 && products_outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mme_pkg.sv
hdl/mme_ram.sv
hdl/mme_mac.sv
hdl/mme_ctrl.sv
hdl/matrix_multiply_engine_top.sv
sim/matrix_product_checker.sv
sim/matrix_multiply_engine_top_tb.sv
